/* rtl/jss_pkg.sv */
// shared types, constants and control store for the joystick and slider scan scaler
package jss_pkg;

	localparam int SAMPLE_BITS_DEF = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 16;
	localparam int SPAN_W          = 8;
	localparam int DZ_W            = 16;
	localparam int VAL_W           = 17;
	localparam int SCALE_NUM       = 200;
	localparam int SLIDER_BIAS     = 100;
	localparam int VAL_MAX         = 65535;
	localparam int VAL_MIN         = -65536;

	typedef enum logic [1:0] {
		CH_JOY_X = 2'd0,
		CH_JOY_Y = 2'd1,
		CH_LEFT  = 2'd2,
		CH_RIGHT = 2'd3
	} chan_t;

	typedef enum logic [2:0] {
		DIR_NEUTRAL = 3'd0,
		DIR_LEFT    = 3'd1,
		DIR_RIGHT   = 3'd2,
		DIR_UP      = 3'd3,
		DIR_DOWN    = 3'd4
	} dir_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_CENTER    = 3'd0,
		REG_Y_CENTER    = 3'd1,
		REG_X_SPAN      = 3'd2,
		REG_Y_SPAN      = 3'd3,
		REG_LEFT_SPAN   = 3'd4,
		REG_RIGHT_SPAN  = 3'd5,
		REG_X_DEAD_ZONE = 3'd6,
		REG_Y_DEAD_ZONE = 3'd7
	} reg_idx_t;

	// microcode
	typedef logic [2:0] upc_t;

	localparam upc_t STEP_WAIT = 3'd0;
	localparam upc_t STEP_LOAD = 3'd1;
	localparam upc_t STEP_DIV  = 3'd2;
	localparam upc_t STEP_FIX  = 3'd3;
	localparam upc_t STEP_EMIT = 3'd4;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_IN_TAKEN,
		COND_CNT_MORE,
		COND_OUT_FREE,
		COND_ALWAYS
	} cond_t;

	typedef struct packed {
		logic  in_rdy;
		logic  load;
		logic  div_step;
		logic  fix;
		logic  emit;
		logic  hold;
		cond_t cond;
		upc_t  target;
	} ctl_word_t;

	function automatic ctl_word_t ucode(input upc_t step);
		ctl_word_t w;
		w = '{in_rdy: 1'b0, load: 1'b0, div_step: 1'b0, fix: 1'b0, emit: 1'b0,
			hold: 1'b0, cond: COND_ALWAYS, target: STEP_WAIT};
		case (step)
			STEP_WAIT: begin
				w.in_rdy = 1'b1;
				w.hold   = 1'b1;
				w.cond   = COND_IN_TAKEN;
				w.target = STEP_LOAD;
			end
			STEP_LOAD: begin
				w.load = 1'b1;
				w.cond = COND_NEVER;
			end
			STEP_DIV: begin
				w.div_step = 1'b1;
				w.cond     = COND_CNT_MORE;
				w.target   = STEP_DIV;
			end
			STEP_FIX: begin
				w.fix  = 1'b1;
				w.cond = COND_NEVER;
			end
			STEP_EMIT: begin
				w.emit   = 1'b1;
				w.hold   = 1'b1;
				w.cond   = COND_OUT_FREE;
				w.target = STEP_WAIT;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

/* rtl/jss_if.sv */
// valid/ready channel interfaces for samples and scaled results
interface jss_sample_if #(
	parameter int SAMPLE_BITS = jss_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface jss_result_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      channel;
	logic signed [jss_pkg::VAL_W-1:0] scaled;
	logic [1:0]                      next_channel;
	logic [2:0]                      direction;

	modport source (output valid, output channel, output scaled, output next_channel,
		output direction, input ready);
	modport sink (input valid, input channel, input scaled, input next_channel,
		input direction, output ready);
endinterface

/* rtl/joystick_slider_scan_scaler.sv */
// joystick and slider scan scaler: microcoded sequencer with bit-serial divider
// one sample is in work at a time, taken only in the wait step; the pace is set by the
//   restoring divider, which retires one quotient bit per cycle
// the output register holds a result until taken; the next sample is accepted meanwhile
// reset (arst_n low): phase joystick X, positions zero, registers to defaults, output empty
module joystick_slider_scan_scaler #(
	parameter int SAMPLE_BITS = jss_pkg::SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	jss_sample_if.sink                         samples,
	jss_result_if.source                       results,
	input  logic                               cfg_we,
	input  logic [jss_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [jss_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int MAG_BITS = SAMPLE_BITS + 8;
	localparam int WIDE_W   = MAG_BITS + 2;
	localparam int CNT_W    = $clog2(MAG_BITS);
	localparam int SW       = jss_pkg::SPAN_W;
	localparam int VW       = jss_pkg::VAL_W;

	localparam logic signed [WIDE_W-1:0] WIDE_MAX  = WIDE_W'(jss_pkg::VAL_MAX);
	localparam logic signed [WIDE_W-1:0] WIDE_MIN  = WIDE_W'(jss_pkg::VAL_MIN);
	localparam logic signed [WIDE_W-1:0] WIDE_BIAS = WIDE_W'(jss_pkg::SLIDER_BIAS);

	// configuration registers
	logic [SW-1:0]              x_center_q, y_center_q;
	logic [SW-1:0]              x_span_q, y_span_q, left_span_q, right_span_q;
	logic [jss_pkg::DZ_W-1:0]   x_dz_q, y_dz_q;

	// sequencer and datapath state
	jss_pkg::upc_t              upc_q;
	jss_pkg::ctl_word_t         ctl;
	logic [1:0]                 phase_q;
	logic [1:0]                 ch_q;
	logic [SAMPLE_BITS-1:0]     sample_q;
	logic                       neg_q;
	logic [MAG_BITS-1:0]        quo_q;
	logic [SW-1:0]              rem_q;
	logic [SW-1:0]              div_q;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [VW-1:0]       x_pos_q, y_pos_q;
	logic signed [VW-1:0]       val_q;

	// output register
	logic                       out_vld_q;
	logic [1:0]                 out_ch_q, out_next_q;
	logic signed [VW-1:0]       out_val_q;
	logic [2:0]                 out_dir_q;

	logic                       in_take;
	logic                       out_free;
	logic                       cond_hit;
	logic                       emit_fire;
	jss_pkg::upc_t              upc_d;

	logic                       is_joy;
	logic [SW-1:0]              ctr;
	logic [SW-1:0]              span;
	logic [SAMPLE_BITS:0]       diff;
	logic                       neg_d;
	logic [SAMPLE_BITS:0]       mag_full;
	logic [MAG_BITS-1:0]        num;

	logic [SW:0]                rem_sh;
	logic [SW:0]                trial;
	logic                       ge;

	logic signed [WIDE_W-1:0]   q_wide;
	logic signed [WIDE_W-1:0]   signed_q;
	logic signed [WIDE_W-1:0]   biased;
	logic signed [VW-1:0]       sat_val;

	logic [VW-1:0]              ax, ay;
	logic [2:0]                 dir_d;

	assign ctl       = jss_pkg::ucode(upc_q);
	assign samples.ready = ctl.in_rdy;
	assign in_take   = samples.valid && ctl.in_rdy;
	assign out_free  = !out_vld_q || results.ready;
	assign emit_fire = ctl.emit && out_free;

	// next step
	always_comb begin
		case (ctl.cond)
			jss_pkg::COND_NEVER:    cond_hit = 1'b0;
			jss_pkg::COND_IN_TAKEN: cond_hit = samples.valid;
			jss_pkg::COND_CNT_MORE: cond_hit = (cnt_q != '0);
			jss_pkg::COND_OUT_FREE: cond_hit = out_free;
			jss_pkg::COND_ALWAYS:   cond_hit = 1'b1;
			default:                cond_hit = 1'b1;
		endcase
		if (cond_hit) begin
			upc_d = ctl.target;
		end else if (ctl.hold) begin
			upc_d = upc_q;
		end else begin
			upc_d = upc_q + 3'd1;
		end
	end

	// operand setup for the divider
	always_comb begin
		is_joy = (ch_q == jss_pkg::CH_JOY_X) || (ch_q == jss_pkg::CH_JOY_Y);
		case (ch_q)
			jss_pkg::CH_JOY_X: begin
				ctr  = x_center_q;
				span = x_span_q;
			end
			jss_pkg::CH_JOY_Y: begin
				ctr  = y_center_q;
				span = y_span_q;
			end
			jss_pkg::CH_LEFT: begin
				ctr  = '0;
				span = left_span_q;
			end
			default: begin
				ctr  = '0;
				span = right_span_q;
			end
		endcase
		diff     = {1'b0, sample_q} - (SAMPLE_BITS+1)'(ctr);
		neg_d    = is_joy && diff[SAMPLE_BITS];
		mag_full = neg_d ? -diff : diff;
		num      = MAG_BITS'(mag_full[SAMPLE_BITS-1:0]) * MAG_BITS'(jss_pkg::SCALE_NUM);
	end

	// one restoring step
	always_comb begin
		rem_sh = {rem_q, quo_q[MAG_BITS-1]};
		ge     = (rem_sh >= {1'b0, div_q});
		trial  = rem_sh - {1'b0, div_q};
	end

	// sign, slider bias and clamp
	always_comb begin
		q_wide   = $signed(WIDE_W'(quo_q));
		signed_q = neg_q ? -q_wide : q_wide;
		biased   = (ch_q == jss_pkg::CH_LEFT || ch_q == jss_pkg::CH_RIGHT)
			? signed_q - WIDE_BIAS : signed_q;
		if (biased > WIDE_MAX) begin
			sat_val = VW'(WIDE_MAX);
		end else if (biased < WIDE_MIN) begin
			sat_val = VW'(WIDE_MIN);
		end else begin
			sat_val = biased[VW-1:0];
		end
	end

	// dominant axis against its dead zone
	always_comb begin
		ax = x_pos_q[VW-1] ? VW'(-x_pos_q) : VW'(x_pos_q);
		ay = y_pos_q[VW-1] ? VW'(-y_pos_q) : VW'(y_pos_q);
		if (ax >= ay) begin
			if (ax < VW'(x_dz_q)) begin
				dir_d = jss_pkg::DIR_NEUTRAL;
			end else if (x_pos_q[VW-1]) begin
				dir_d = jss_pkg::DIR_LEFT;
			end else begin
				dir_d = jss_pkg::DIR_RIGHT;
			end
		end else begin
			if (ay < VW'(y_dz_q)) begin
				dir_d = jss_pkg::DIR_NEUTRAL;
			end else if (y_pos_q[VW-1]) begin
				dir_d = jss_pkg::DIR_DOWN;
			end else begin
				dir_d = jss_pkg::DIR_UP;
			end
		end
	end

	// control state, configuration and stored positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q        <= jss_pkg::STEP_WAIT;
			phase_q      <= jss_pkg::CH_JOY_X;
			out_vld_q    <= 1'b0;
			x_pos_q      <= '0;
			y_pos_q      <= '0;
			x_center_q   <= '0;
			y_center_q   <= '0;
			x_span_q     <= 8'd255;
			y_span_q     <= 8'd255;
			left_span_q  <= 8'd255;
			right_span_q <= 8'd255;
			x_dz_q       <= 16'd10;
			y_dz_q       <= 16'd65;
		end else begin
			upc_q <= upc_d;
			if (in_take) begin
				phase_q <= phase_q + 2'd1;
			end
			if (emit_fire) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
			if (ctl.fix) begin
				if (ch_q == jss_pkg::CH_JOY_X) begin
					x_pos_q <= sat_val;
				end
				if (ch_q == jss_pkg::CH_JOY_Y) begin
					y_pos_q <= sat_val;
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					jss_pkg::REG_X_CENTER:    x_center_q   <= cfg_wdata[SW-1:0];
					jss_pkg::REG_Y_CENTER:    y_center_q   <= cfg_wdata[SW-1:0];
					jss_pkg::REG_X_SPAN:      x_span_q     <= cfg_wdata[SW-1:0];
					jss_pkg::REG_Y_SPAN:      y_span_q     <= cfg_wdata[SW-1:0];
					jss_pkg::REG_LEFT_SPAN:   left_span_q  <= cfg_wdata[SW-1:0];
					jss_pkg::REG_RIGHT_SPAN:  right_span_q <= cfg_wdata[SW-1:0];
					jss_pkg::REG_X_DEAD_ZONE: x_dz_q       <= cfg_wdata;
					jss_pkg::REG_Y_DEAD_ZONE: y_dz_q       <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_q <= samples.sample;
			ch_q     <= phase_q;
		end
		if (ctl.load) begin
			neg_q <= neg_d;
			quo_q <= num;
			rem_q <= '0;
			div_q <= (span == '0) ? SW'(1) : span;
			cnt_q <= CNT_W'(MAG_BITS - 1);
		end
		if (ctl.div_step) begin
			quo_q <= {quo_q[MAG_BITS-2:0], ge};
			rem_q <= ge ? trial[SW-1:0] : rem_sh[SW-1:0];
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (ctl.fix) begin
			val_q <= sat_val;
		end
		if (emit_fire) begin
			out_ch_q   <= ch_q;
			out_val_q  <= val_q;
			out_next_q <= phase_q;
			out_dir_q  <= dir_d;
		end
	end

	assign results.valid        = out_vld_q;
	assign results.channel      = out_ch_q;
	assign results.scaled       = out_val_q;
	assign results.next_channel = out_next_q;
	assign results.direction    = out_dir_q;

endmodule

/* rtl/jss_checker.sv */
// port-level assertions for the scan scaler, bound to the top level
module jss_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [1:0]                   channel,
	input logic [jss_pkg::VAL_W-1:0]    scaled,
	input logic [1:0]                   next_channel,
	input logic [2:0]                   direction
);

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(channel) && $stable(scaled)
			&& $stable(next_channel) && $stable(direction))
		else $error("stalled result changed");

	// one sample in flight: no second transaction right after one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample accepted while one is in work");

	// the round robin advances by one
	a_next_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> next_channel == 2'(channel + 2'd1))
		else $error("next channel out of sequence");

	a_direction_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> direction <= 3'd4)
		else $error("direction code out of range");

	// consecutive results come from consecutive channels
	a_channel_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid || $past(next_channel) == channel)
		else $error("channel skipped or repeated");

endmodule

bind joystick_slider_scan_scaler jss_checker u_jss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (samples.valid),
	.in_ready     (samples.ready),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.channel      (results.channel),
	.scaled       (results.scaled),
	.next_channel (results.next_channel),
	.direction    (results.direction)
);

/* dv/tb_joystick_slider_scan_scaler.sv */
// self-checking testbench for the joystick and slider scan scaler with a scoreboard class
module tb_joystick_slider_scan_scaler;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_W        = 8;
	localparam int NUM_REGS        = 8;
	localparam int RAND_PHASES     = 8;
	localparam int ITEMS_PER_PHASE = 163;
	localparam int LONG_HOLD       = 300;
	localparam int IDLE_LIMIT      = 2000;
	localparam int SETTLE_CYCLES   = 3;
	localparam int DRAIN_CYCLES    = 40;
	localparam int REPORT_LIMIT    = 10;

	typedef struct {
		jss_pkg::chan_t                   channel;
		logic signed [jss_pkg::VAL_W-1:0] scaled;
		jss_pkg::chan_t                   next_channel;
		jss_pkg::dir_t                    direction;
	} scan_result_t;

	class scaler_scoreboard;
		logic [jss_pkg::SPAN_W-1:0] x_center, y_center, x_span, y_span, left_span, right_span;
		logic [jss_pkg::DZ_W-1:0]   x_dead_zone, y_dead_zone;
		jss_pkg::chan_t             phase;
		int                         x_pos, y_pos, left_lvl, right_lvl;
		scan_result_t               pending_scans[$];
		int unsigned                failures;
		int unsigned                checked;

		function new();
			x_center    = '0;
			y_center    = '0;
			x_span      = 8'd255;
			y_span      = 8'd255;
			left_span   = 8'd255;
			right_span  = 8'd255;
			x_dead_zone = 16'd10;
			y_dead_zone = 16'd65;
			phase       = jss_pkg::CH_JOY_X;
			x_pos       = 0;
			y_pos       = 0;
			left_lvl    = 0;
			right_lvl   = 0;
			failures    = 0;
			checked     = 0;
		endfunction

		function void write_reg(jss_pkg::reg_idx_t idx,
				logic [jss_pkg::CFG_DATA_W-1:0] value);
			case (idx)
				jss_pkg::REG_X_CENTER:    x_center    = value[jss_pkg::SPAN_W-1:0];
				jss_pkg::REG_Y_CENTER:    y_center    = value[jss_pkg::SPAN_W-1:0];
				jss_pkg::REG_X_SPAN:      x_span      = value[jss_pkg::SPAN_W-1:0];
				jss_pkg::REG_Y_SPAN:      y_span      = value[jss_pkg::SPAN_W-1:0];
				jss_pkg::REG_LEFT_SPAN:   left_span   = value[jss_pkg::SPAN_W-1:0];
				jss_pkg::REG_RIGHT_SPAN:  right_span  = value[jss_pkg::SPAN_W-1:0];
				jss_pkg::REG_X_DEAD_ZONE: x_dead_zone = value[jss_pkg::DZ_W-1:0];
				jss_pkg::REG_Y_DEAD_ZONE: y_dead_zone = value[jss_pkg::DZ_W-1:0];
				default: ;
			endcase
		endfunction

		// divide with truncation toward zero, a zero span acts as one
		function int scale_ratio(int num, logic [jss_pkg::SPAN_W-1:0] span);
			int d;
			int mag;
			d   = (span == 0) ? 1 : int'(span);
			mag = ((num < 0) ? -num : num) / d;
			return (num < 0) ? -mag : mag;
		endfunction

		function int clamp_value(int v);
			if (v > jss_pkg::VAL_MAX)
				return jss_pkg::VAL_MAX;
			if (v < jss_pkg::VAL_MIN)
				return jss_pkg::VAL_MIN;
			return v;
		endfunction

		function jss_pkg::dir_t stick_direction();
			int ax;
			int ay;
			ax = (x_pos < 0) ? -x_pos : x_pos;
			ay = (y_pos < 0) ? -y_pos : y_pos;
			if (ax >= ay) begin
				if (ax < int'(x_dead_zone))
					return jss_pkg::DIR_NEUTRAL;
				return (x_pos < 0) ? jss_pkg::DIR_LEFT : jss_pkg::DIR_RIGHT;
			end
			if (ay < int'(y_dead_zone))
				return jss_pkg::DIR_NEUTRAL;
			return (y_pos < 0) ? jss_pkg::DIR_DOWN : jss_pkg::DIR_UP;
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] s);
			int           sv;
			int           v;
			scan_result_t r;
			sv = int'(s);
			case (phase)
				jss_pkg::CH_JOY_X: begin
					v = clamp_value(scale_ratio((sv - int'(x_center)) * jss_pkg::SCALE_NUM,
						x_span));
					x_pos = v;
				end
				jss_pkg::CH_JOY_Y: begin
					v = clamp_value(scale_ratio((sv - int'(y_center)) * jss_pkg::SCALE_NUM,
						y_span));
					y_pos = v;
				end
				jss_pkg::CH_LEFT: begin
					v = clamp_value(scale_ratio(sv * jss_pkg::SCALE_NUM, left_span)
						- jss_pkg::SLIDER_BIAS);
					left_lvl = v;
				end
				default: begin
					v = clamp_value(scale_ratio(sv * jss_pkg::SCALE_NUM, right_span)
						- jss_pkg::SLIDER_BIAS);
					right_lvl = v;
				end
			endcase
			r.channel      = phase;
			phase          = jss_pkg::chan_t'((int'(phase) + 1) % 4);
			r.scaled       = v[jss_pkg::VAL_W-1:0];
			r.next_channel = phase;
			r.direction    = stick_direction();
			pending_scans.push_back(r);
		endfunction

		function void note_failure(string what);
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("mismatch: %s", what);
		endfunction

		function void check_result(jss_pkg::chan_t ch, logic signed [jss_pkg::VAL_W-1:0] val,
				jss_pkg::chan_t nxt, jss_pkg::dir_t dir);
			scan_result_t e;
			if (pending_scans.size() == 0) begin
				note_failure($sformatf("unexpected result ch %0d scaled %0d next %0d dir %0d",
					ch, val, nxt, dir));
				return;
			end
			e = pending_scans.pop_front();
			checked++;
			if (ch !== e.channel || val !== e.scaled || nxt !== e.next_channel ||
					dir !== e.direction)
				note_failure($sformatf(
					"scan %0d expected ch %0d scaled %0d next %0d dir %0d, got %0d %0d %0d %0d",
					checked, e.channel, e.scaled, e.next_channel, e.direction,
					ch, val, nxt, dir));
		endfunction

		function void flush_check();
			if (pending_scans.size() != 0) begin
				failures += pending_scans.size();
				$display("%0d scans still pending at end of run", pending_scans.size());
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [jss_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [jss_pkg::CFG_DATA_W-1:0] cfg_wdata;

	jss_sample_if #(.SAMPLE_BITS(SAMPLE_W)) samples_if ();
	jss_result_if                           results_if ();

	joystick_slider_scan_scaler #(
		.SAMPLE_BITS(SAMPLE_W)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_if),
		.results   (results_if),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	scaler_scoreboard               sb;
	logic [jss_pkg::CFG_DATA_W-1:0] reg_plan [NUM_REGS];
	bit                             src_gaps;
	bit                             sink_gaps;
	bit                             hold_req;
	int unsigned                    n_sent;
	int unsigned                    n_settings;
	int unsigned                    n_holds;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		if (r < 20)
			return '1;
		return SAMPLE_W'($urandom_range(255));
	endfunction

	function automatic logic [jss_pkg::CFG_DATA_W-1:0] pick_center();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return '0;
		if (r < 30)
			return 16'd255;
		return 16'($urandom_range(255));
	endfunction

	function automatic logic [jss_pkg::CFG_DATA_W-1:0] pick_span();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 16)
			return 16'd1;
		if (r < 28)
			return 16'd255;
		return 16'($urandom_range(1, 255));
	endfunction

	function automatic logic [jss_pkg::CFG_DATA_W-1:0] pick_dead_zone();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 14)
			return 16'hFFFF;
		if (r < 22)
			return 16'($urandom_range(65535));
		return 16'($urandom_range(0, 400));
	endfunction

	task automatic apply_reg_plan();
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we    <= 1'b1;
			cfg_idx   <= jss_pkg::reg_idx_t'(i);
			cfg_wdata <= reg_plan[i];
			@(posedge clk);
			sb.write_reg(jss_pkg::reg_idx_t'(i), reg_plan[i]);
		end
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit gaps_on);
		int gap;
		samples_if.valid  <= 1'b1;
		samples_if.sample <= s;
		do
			@(posedge clk);
		while (!samples_if.ready);
		sb.note_sample(s);
		n_sent++;
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// one sample per channel, joystick X first
	task automatic send_round(input logic [SAMPLE_W-1:0] jx, input logic [SAMPLE_W-1:0] jy,
			input logic [SAMPLE_W-1:0] sl, input logic [SAMPLE_W-1:0] sr);
		send_sample(jx, 1'b1);
		send_sample(jy, 1'b1);
		send_sample(sl, 1'b1);
		send_sample(sr, 1'b1);
	endtask

	task automatic wait_drained();
		samples_if.valid <= 1'b0;
		while (sb.pending_scans.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result side: random stalls plus one long hold on request
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (results_if.valid && results_if.ready)
				sb.check_result(jss_pkg::chan_t'(results_if.channel), results_if.scaled,
					jss_pkg::chan_t'(results_if.next_channel),
					jss_pkg::dir_t'(results_if.direction));
			if (hold_req) begin
				stall_left = LONG_HOLD;
				hold_req   = 1'b0;
				n_holds++;
			end else if (stall_left > 0)
				stall_left--;
			else if (sink_gaps && $urandom_range(99) < 30)
				stall_left = pick_gap();
			results_if.ready <= (stall_left == 0);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready))
				idle = 0;
			else
				idle++;
		end
		$display("no transaction for %0d cycles", IDLE_LIMIT);
		$display("tb_joystick_slider_scan_scaler failed");
		$finish;
	end

	initial begin : stimulus
		sb                = new();
		src_gaps          = 1'b1;
		sink_gaps         = 1'b1;
		hold_req          = 1'b0;
		n_sent            = 0;
		n_settings        = 0;
		n_holds           = 0;
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_idx           <= jss_pkg::REG_X_CENTER;
		cfg_wdata         <= '0;
		samples_if.valid  <= 1'b0;
		samples_if.sample <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: neutral, up, right and both slider ends
		send_round(8'd0, 8'd255, 8'd0, 8'd255);
		send_round(8'd255, 8'd0, 8'd255, 8'd0);
		wait_drained();

		// largest offsets with unit spans and no dead zone: down, left, y at zero
		reg_plan[jss_pkg::REG_X_CENTER]    = 16'd255;
		reg_plan[jss_pkg::REG_Y_CENTER]    = 16'd255;
		reg_plan[jss_pkg::REG_X_SPAN]      = 16'd1;
		reg_plan[jss_pkg::REG_Y_SPAN]      = 16'd1;
		reg_plan[jss_pkg::REG_LEFT_SPAN]   = 16'd1;
		reg_plan[jss_pkg::REG_RIGHT_SPAN]  = 16'd1;
		reg_plan[jss_pkg::REG_X_DEAD_ZONE] = 16'd0;
		reg_plan[jss_pkg::REG_Y_DEAD_ZONE] = 16'd0;
		apply_reg_plan();
		send_round(8'd128, 8'd0, 8'd255, 8'd255);
		send_round(8'd0, 8'd255, 8'd0, 8'd0);
		wait_drained();

		// zero spans divide by one, widest dead zones keep the stick neutral
		reg_plan[jss_pkg::REG_X_CENTER]    = 16'd0;
		reg_plan[jss_pkg::REG_Y_CENTER]    = 16'd0;
		reg_plan[jss_pkg::REG_X_SPAN]      = 16'd0;
		reg_plan[jss_pkg::REG_Y_SPAN]      = 16'd0;
		reg_plan[jss_pkg::REG_LEFT_SPAN]   = 16'd0;
		reg_plan[jss_pkg::REG_RIGHT_SPAN]  = 16'd0;
		reg_plan[jss_pkg::REG_X_DEAD_ZONE] = 16'hFFFF;
		reg_plan[jss_pkg::REG_Y_DEAD_ZONE] = 16'hFFFF;
		apply_reg_plan();
		send_round(8'd255, 8'd1, 8'd128, 8'd0);
		send_round(8'd0, 8'd255, 8'd255, 8'd1);
		wait_drained();

		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == 0) begin
				reg_plan[jss_pkg::REG_X_CENTER]    = 16'd128;
				reg_plan[jss_pkg::REG_Y_CENTER]    = 16'd128;
				reg_plan[jss_pkg::REG_X_SPAN]      = 16'd255;
				reg_plan[jss_pkg::REG_Y_SPAN]      = 16'd255;
				reg_plan[jss_pkg::REG_LEFT_SPAN]   = 16'd255;
				reg_plan[jss_pkg::REG_RIGHT_SPAN]  = 16'd255;
				reg_plan[jss_pkg::REG_X_DEAD_ZONE] = 16'd10;
				reg_plan[jss_pkg::REG_Y_DEAD_ZONE] = 16'd65;
			end else begin
				reg_plan[jss_pkg::REG_X_CENTER]    = pick_center();
				reg_plan[jss_pkg::REG_Y_CENTER]    = pick_center();
				reg_plan[jss_pkg::REG_X_SPAN]      = pick_span();
				reg_plan[jss_pkg::REG_Y_SPAN]      = pick_span();
				reg_plan[jss_pkg::REG_LEFT_SPAN]   = pick_span();
				reg_plan[jss_pkg::REG_RIGHT_SPAN]  = pick_span();
				reg_plan[jss_pkg::REG_X_DEAD_ZONE] = pick_dead_zone();
				reg_plan[jss_pkg::REG_Y_DEAD_ZONE] = pick_dead_zone();
			end
			apply_reg_plan();
			// one phase runs back to back on both sides
			src_gaps  = (p != 2);
			sink_gaps = (p != 2);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (p == 1 && k == 30)
					hold_req = 1'b1;
				if (p == 3 && k == 80)
					wait_drained();
				send_sample(pick_sample(), src_gaps);
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.flush_check();
		$display("covered %0d samples over %0d register settings, %0d results checked",
			n_sent, n_settings, sb.checked);
		$display("output held off %0d time(s) for %0d cycles, %0d failure(s)",
			n_holds, LONG_HOLD, sb.failures);
		if (sb.failures == 0)
			$display("tb_joystick_slider_scan_scaler passed");
		else
			$display("tb_joystick_slider_scan_scaler failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/jss_pkg.sv
rtl/jss_if.sv
rtl/joystick_slider_scan_scaler.sv
rtl/jss_checker.sv
dv/tb_joystick_slider_scan_scaler.sv
